// ===== rtl/tfmc_pkg.sv =====
// Shared types and constants for the turn-follow mode controller.
package tfmc_pkg;

    localparam int YAW_W   = 16;
    localparam int THR_W   = 15;
    localparam int CNT_W   = 8;
    localparam int SCALE_W = 9;
    localparam int NUM_W   = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Consecutive invalid gate frames that end a turn.
    localparam logic [1:0] INVALID_LIMIT = 2'd3;

    localparam logic [1:0] MODE_STAB    = 2'd0;
    localparam logic [1:0] MODE_TURN    = 2'd1;
    localparam logic [1:0] MODE_RECOVER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ENTER_THR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXIT_THR  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY  = 8'd3;

    localparam logic [SCALE_W-1:0] SCALE_FULL = 9'd256;
    localparam logic [SCALE_W-1:0] SCALE_NONE = 9'd0;

    typedef struct packed {
        logic load;      // take the input beat and update the mode state
        logic div_step;  // one restoring-division step
        logic out_load;  // move the finished result into the output register
    } tfmc_cmd_t;

    typedef struct packed {
        logic recover_next;  // the beat being taken lands in recover
    } tfmc_status_t;

endpackage

// ===== rtl/tfmc_ctrl.sv =====
// Sequencer: input handshake, divide step counting and output register valid.
module tfmc_ctrl
    import tfmc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  tfmc_status_t status,
    output tfmc_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int STEP_W = $clog2(NUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = status.recover_next ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // The output register frees up in the same cycle its beat is taken.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/tfmc_dp.sv =====
// Datapath: config registers, mode state update, ramp divider and output register.
module tfmc_dp
    import tfmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  gate_ok,
    input  logic signed [YAW_W-1:0] yaw_rate,
    input  tfmc_cmd_t             cmd,
    output tfmc_status_t          status,
    output logic [1:0]            mode,
    output logic                  turn_entered,
    output logic [SCALE_W-1:0]    corr_weight
);

    logic [THR_W-1:0] enter_thr_reg, exit_thr_reg;
    logic [CNT_W-1:0] hold_reg, recovery_reg;

    logic [1:0]       mode_reg, mode_next;
    logic [CNT_W-1:0] enter_cnt_reg, enter_cnt_next;
    logic [CNT_W-1:0] exit_cnt_reg, exit_cnt_next;
    logic [1:0]       inv_cnt_reg, inv_cnt_next;
    logic [CNT_W-1:0] left_reg, left_next;

    logic [1:0]       res_mode_reg;
    logic             res_entered_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] den_reg;

    logic [1:0]         out_mode_reg;
    logic               out_entered_reg;
    logic [SCALE_W-1:0] out_scale_reg;

    logic [YAW_W:0]   mag;
    logic             above_enter, below_exit;
    logic [CNT_W-1:0] hold_eff, total;
    logic [CNT_W-1:0] enter_inc, exit_inc, left_dec, left_clip;
    logic [1:0]       inv_inc;
    logic [NUM_W-1:0] num_init;
    logic [CNT_W:0]   trial;
    logic             fits;
    logic [SCALE_W-1:0] scale_sel;

    // Magnitude is one bit wider so that the most negative rate stays above every threshold.
    assign mag    = yaw_rate[YAW_W-1] ? ((YAW_W+1)'(~yaw_rate) + 1'b1)
                                      : {1'b0, yaw_rate};
    assign above_enter = gate_ok && (mag >= {2'b00, enter_thr_reg});
    assign below_exit  = mag <= {2'b00, exit_thr_reg};

    assign hold_eff  = (hold_reg == '0) ? CNT_W'(1) : hold_reg;
    assign total     = (recovery_reg == '0) ? CNT_W'(1) : recovery_reg;
    assign enter_inc = (enter_cnt_reg == '1) ? enter_cnt_reg : enter_cnt_reg + 1'b1;
    assign exit_inc  = (exit_cnt_reg == '1) ? exit_cnt_reg : exit_cnt_reg + 1'b1;
    assign inv_inc   = (inv_cnt_reg == '1) ? inv_cnt_reg : inv_cnt_reg + 1'b1;
    assign left_dec  = (left_reg == '0) ? left_reg : left_reg - 1'b1;

    always_comb
    begin
        mode_next      = mode_reg;
        enter_cnt_next = enter_cnt_reg;
        exit_cnt_next  = exit_cnt_reg;
        inv_cnt_next   = inv_cnt_reg;
        left_next      = left_reg;
        case (mode_reg)
            MODE_TURN:
            begin
                if (!gate_ok)
                begin
                    exit_cnt_next = '0;
                    inv_cnt_next  = inv_inc;
                    if (inv_inc >= INVALID_LIMIT)
                    begin
                        mode_next    = MODE_RECOVER;
                        left_next    = total;
                        inv_cnt_next = '0;
                    end
                end
                else
                begin
                    inv_cnt_next = '0;
                    if (below_exit)
                    begin
                        exit_cnt_next = exit_inc;
                        if (exit_inc >= hold_eff)
                        begin
                            mode_next     = MODE_RECOVER;
                            left_next     = total;
                            exit_cnt_next = '0;
                        end
                    end
                    else
                    begin
                        exit_cnt_next = '0;
                    end
                end
            end
            MODE_RECOVER:
            begin
                inv_cnt_next = '0;
                if (above_enter)
                begin
                    mode_next      = MODE_TURN;
                    enter_cnt_next = '0;
                    exit_cnt_next  = '0;
                    left_next      = '0;
                end
                else
                begin
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        mode_next = MODE_STAB;
                    end
                end
            end
            default:
            begin
                // Stabilize, and the unused code treated the same way.
                mode_next    = MODE_STAB;
                inv_cnt_next = '0;
                if (above_enter)
                begin
                    enter_cnt_next = enter_inc;
                    if (enter_inc >= hold_eff)
                    begin
                        mode_next      = MODE_TURN;
                        enter_cnt_next = '0;
                        exit_cnt_next  = '0;
                        left_next      = '0;
                    end
                end
                else
                begin
                    enter_cnt_next = '0;
                end
            end
        endcase
    end

    assign status.recover_next = (mode_next == MODE_RECOVER);

    // Ramp numerator (T - L) * 256 + T / 2, divided by T one quotient bit per cycle.
    assign left_clip = (left_next > total) ? total : left_next;
    assign num_init  = {total - left_clip, CNT_W'(0)} + NUM_W'(total[CNT_W-1:1]);
    assign trial     = {rem_reg, quo_reg[NUM_W-1]};
    assign fits      = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_thr_reg <= '0;
            exit_thr_reg  <= '0;
            hold_reg      <= CNT_W'(1);
            recovery_reg  <= CNT_W'(1);
            mode_reg      <= MODE_STAB;
            enter_cnt_reg <= '0;
            exit_cnt_reg  <= '0;
            inv_cnt_reg   <= '0;
            left_reg      <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_index)
                    REG_ENTER_THR: enter_thr_reg <= cfg_data[THR_W-1:0];
                    REG_EXIT_THR:  exit_thr_reg  <= cfg_data[THR_W-1:0];
                    REG_HOLD:      hold_reg      <= cfg_data[CNT_W-1:0];
                    REG_RECOVERY:  recovery_reg  <= cfg_data[CNT_W-1:0];
                    default:       ;
                endcase
            end
            if (cmd.load)
            begin
                mode_reg      <= mode_next;
                enter_cnt_reg <= enter_cnt_next;
                exit_cnt_reg  <= exit_cnt_next;
                inv_cnt_reg   <= inv_cnt_next;
                left_reg      <= left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_mode_reg    <= mode_next;
            res_entered_reg <= (mode_next == MODE_TURN) && (mode_reg != MODE_TURN);
            quo_reg         <= num_init;
            rem_reg         <= '0;
            den_reg         <= total;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? CNT_W'(trial - {1'b0, den_reg}) : trial[CNT_W-1:0];
        end
    end

    always_comb
    begin
        case (res_mode_reg)
            MODE_TURN:    scale_sel = SCALE_NONE;
            MODE_RECOVER: scale_sel = quo_reg[SCALE_W-1:0];
            default:      scale_sel = SCALE_FULL;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_mode_reg    <= res_mode_reg;
            out_entered_reg <= res_entered_reg;
            out_scale_reg   <= scale_sel;
        end
    end

    assign mode         = out_mode_reg;
    assign turn_entered = out_entered_reg;
    assign corr_weight  = out_scale_reg;

endmodule

// ===== rtl/turn_follow_mode_controller_top.sv =====
// Top level of the turn-follow mode controller.
//
// One input beat per video frame carries gate_ok and a signed yaw_rate; the
// block answers every input beat with exactly one output beat holding mode,
// turn_entered and corr_weight. Both streams use valid/stall: a beat
// moves on a rising edge with valid high and stall low.
// A frame that ends in stabilize or turn follow moves its result to the output
// register once that register is free. A frame that ends in recover first runs
// the ramp divide, a restoring divider that makes one quotient bit per cycle,
// and then moves its result on the same way. One frame is worked at a time, so
// no new input beat is taken until the last frame's result is in the output register.
// The output register holds a finished beat while the next frame is worked;
// when the receiver stalls, that next result waits and input stays stalled.
// Configuration writes (cfg_index 0 to 3) are always ready; other indexes are dropped.
// The user must make writes while the block is idle; the block does not enforce this.
// Reset returns thresholds to zero, hold and recovery lengths to one, mode to stabilize.
module turn_follow_mode_controller_top
    import tfmc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    gate_ok,
    input  logic signed [YAW_W-1:0] yaw_rate,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              mode,
    output logic                    turn_entered,
    output logic [SCALE_W-1:0]      corr_weight
);

    tfmc_cmd_t    cmd;
    tfmc_status_t status;

    assign cfg_ready = 1'b1;

    tfmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tfmc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .gate_ok      (gate_ok),
        .yaw_rate     (yaw_rate),
        .cmd          (cmd),
        .status       (status),
        .mode         (mode),
        .turn_entered (turn_entered),
        .corr_weight  (corr_weight)
    );

    // A taken frame blocks the input until its result reaches the output register.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a frame was taken");

    a_entered_in_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && turn_entered) |-> (mode == MODE_TURN))
        else $error("turn entry flagged outside turn follow");

    a_turn_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mode == MODE_TURN) |-> (corr_weight == SCALE_NONE))
        else $error("nonzero correction in turn follow");

    a_stab_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mode == MODE_STAB) |-> (corr_weight == SCALE_FULL))
        else $error("partial correction in stabilize");

endmodule

// ===== verif/turn_follow_mode_controller_top_test.sv =====
// Self-checking testbench for the turn-follow mode controller: directed table, then random frames.
`timescale 1ns / 100ps

module turn_follow_mode_controller_top_test;
    import tfmc_pkg::*;

    localparam int ROW_FRAME = 0;
    localparam int ROW_CFG   = 1;

    localparam int RG_TURN  = 0;
    localparam int RG_CALM  = 1;
    localparam int RG_MID   = 2;
    localparam int RG_DROP  = 3;
    localparam int RG_NOISE = 4;

    localparam int FRAME_TARGET    = 1650;
    localparam int QUIET_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct packed {
        logic [1:0]         mode;
        logic               entered;
        logic [SCALE_W-1:0] scale;
    } frame_result_t;

    typedef struct {
        int kind;
        int idx;
        int data;
        bit gv;
        int yaw;
        bit typed;
        int e_mode;
        bit e_ent;
        int e_scale;
    } dir_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    gate_ok;
    logic signed [YAW_W-1:0] yaw_rate;
    logic                    out_valid;
    logic                    out_stall;
    logic [1:0]              mode;
    logic                    turn_entered;
    logic [SCALE_W-1:0]      corr_weight;

    // Shadow of the controller's registers and mode state.
    logic [THR_W-1:0] enter_thr   = '0;
    logic [THR_W-1:0] exit_thr    = '0;
    logic [CNT_W-1:0] hold_len    = 8'd1;
    logic [CNT_W-1:0] ramp_len    = 8'd1;
    logic [1:0]       mode_now    = MODE_STAB;
    logic [CNT_W-1:0] enter_run   = '0;
    logic [CNT_W-1:0] exit_run    = '0;
    logic [1:0]       invalid_run = '0;
    logic [CNT_W-1:0] ramp_left   = '0;

    frame_result_t expected_frames[$];
    int  mismatches    = 0;
    int  frames_sent   = 0;
    int  quiet_cycles  = 0;
    bit  send_no_idle  = 1'b0;
    bit  recv_no_idle  = 1'b0;
    bit  hold_off_req  = 1'b0;

    dir_row_t dir_rows [39] = '{
        '{ROW_FRAME, 0, 0, 1, 0, 1, MODE_TURN, 1, SCALE_NONE},
        '{ROW_FRAME, 0, 0, 1, 0, 1, MODE_RECOVER, 0, SCALE_NONE},
        '{ROW_FRAME, 0, 0, 0, 0, 1, MODE_STAB, 0, SCALE_FULL},
        '{ROW_CFG, REG_ENTER_THR, 'h83E8, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, REG_EXIT_THR, 200, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, REG_HOLD, 'hFF00, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, REG_RECOVERY, 'hAB00, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, 4, 'h0005, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, 255, 'hFFFF, 0, 0, 0, 0, 0, 0},
        '{ROW_FRAME, 0, 0, 1, -32768, 1, MODE_TURN, 1, SCALE_NONE},
        '{ROW_FRAME, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_FRAME, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_FRAME, 0, 0, 0, 0, 1, MODE_RECOVER, 0, SCALE_NONE},
        '{ROW_FRAME, 0, 0, 0, 32767, 1, MODE_STAB, 0, SCALE_FULL},
        '{ROW_FRAME, 0, 0, 1, 32767, 1, MODE_TURN, 1, SCALE_NONE},
        '{ROW_FRAME, 0, 0, 1, -200, 1, MODE_RECOVER, 0, SCALE_NONE},
        '{ROW_FRAME, 0, 0, 1, 999, 1, MODE_STAB, 0, SCALE_FULL},
        '{ROW_FRAME, 0, 0, 1, 1000, 1, MODE_TURN, 1, SCALE_NONE},
        '{ROW_FRAME, 0, 0, 1, 0, 1, MODE_RECOVER, 0, SCALE_NONE},
        '{ROW_FRAME, 0, 0, 0, 0, 1, MODE_STAB, 0, SCALE_FULL},
        '{ROW_CFG, REG_ENTER_THR, 'h7FFF, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, REG_EXIT_THR, 'hFFFF, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, REG_HOLD, 255, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, REG_RECOVERY, 255, 0, 0, 0, 0, 0, 0},
        '{ROW_FRAME, 0, 0, 1, -32768, 1, MODE_STAB, 0, SCALE_FULL},
        '{ROW_FRAME, 0, 0, 1, 32767, 1, MODE_STAB, 0, SCALE_FULL},
        '{ROW_FRAME, 0, 0, 1, 32766, 1, MODE_STAB, 0, SCALE_FULL},
        '{ROW_CFG, REG_ENTER_THR, 500, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, REG_EXIT_THR, 100, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, REG_HOLD, 2, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, REG_RECOVERY, 3, 0, 0, 0, 0, 0, 0},
        '{ROW_FRAME, 0, 0, 1, 600, 0, 0, 0, 0},
        '{ROW_FRAME, 0, 0, 1, -600, 0, 0, 0, 0},
        '{ROW_FRAME, 0, 0, 1, 50, 0, 0, 0, 0},
        '{ROW_FRAME, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_FRAME, 0, 0, 1, 50, 0, 0, 0, 0},
        '{ROW_FRAME, 0, 0, 1, -100, 0, 0, 0, 0},
        '{ROW_FRAME, 0, 0, 1, 10, 0, 0, 0, 0},
        '{ROW_FRAME, 0, 0, 1, 700, 0, 0, 0, 0}
    };

    turn_follow_mode_controller_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .gate_ok      (gate_ok),
        .yaw_rate     (yaw_rate),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mode         (mode),
        .turn_entered (turn_entered),
        .corr_weight  (corr_weight)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Runs one frame through the shadow mode machine and returns its result.
    function automatic frame_result_t advance_mode(input logic gv, input logic [15:0] yaw);
        logic [16:0]      mag;
        logic [CNT_W-1:0] hold;
        logic [CNT_W-1:0] ramp_total;
        logic [1:0]       prev;
        int               t;
        int               l;
        frame_result_t    r;
        mag = yaw[15] ? (17'h10000 - {1'b0, yaw}) : {1'b0, yaw};
        hold = (hold_len == '0) ? 8'd1 : hold_len;
        ramp_total = (ramp_len == '0) ? 8'd1 : ramp_len;
        prev = mode_now;
        if (mode_now == MODE_TURN)
        begin
            if (!gv)
            begin
                exit_run = '0;
                if (invalid_run != 2'd3)
                    invalid_run = invalid_run + 2'd1;
                if (invalid_run >= INVALID_LIMIT)
                begin
                    mode_now = MODE_RECOVER;
                    ramp_left = ramp_total;
                    invalid_run = '0;
                end
            end
            else
            begin
                invalid_run = '0;
                if (mag <= {2'b0, exit_thr})
                begin
                    if (exit_run != 8'hFF)
                        exit_run = exit_run + 8'd1;
                    if (exit_run >= hold)
                    begin
                        mode_now = MODE_RECOVER;
                        ramp_left = ramp_total;
                        exit_run = '0;
                    end
                end
                else
                    exit_run = '0;
            end
        end
        else if (mode_now == MODE_RECOVER)
        begin
            invalid_run = '0;
            if (gv && mag >= {2'b0, enter_thr})
            begin
                mode_now = MODE_TURN;
                enter_run = '0;
                exit_run = '0;
                ramp_left = '0;
            end
            else
            begin
                if (ramp_left != '0)
                    ramp_left = ramp_left - 8'd1;
                if (ramp_left == '0)
                    mode_now = MODE_STAB;
            end
        end
        else
        begin
            mode_now = MODE_STAB;
            invalid_run = '0;
            if (gv && mag >= {2'b0, enter_thr})
            begin
                if (enter_run != 8'hFF)
                    enter_run = enter_run + 8'd1;
                if (enter_run >= hold)
                begin
                    mode_now = MODE_TURN;
                    enter_run = '0;
                    exit_run = '0;
                    ramp_left = '0;
                end
            end
            else
                enter_run = '0;
        end

        r.mode = mode_now;
        r.entered = (mode_now == MODE_TURN) && (prev != MODE_TURN);
        if (mode_now == MODE_TURN)
            r.scale = SCALE_NONE;
        else if (mode_now == MODE_RECOVER)
        begin
            // Linear ramp back to full weight, rounded to nearest.
            t = ramp_total;
            l = (ramp_left > ramp_total) ? t : int'(ramp_left);
            r.scale = SCALE_W'(((t - l) * 256 + t / 2) / t);
        end
        else
            r.scale = SCALE_FULL;
        return r;
    endfunction

    function automatic int draw_wait(input bit no_idle);
        return no_idle ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic [15:0] yaw_of_mag(input int m);
        if (m >= 32768)
            return 16'h8000;
        return ($urandom_range(0, 1) != 0) ? 16'(-m) : 16'(m);
    endfunction

    // Registers change only once every expected beat has come back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_frames.size() != 0)
            @(negedge clk);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_ENTER_THR: enter_thr = data[THR_W-1:0];
            REG_EXIT_THR:  exit_thr = data[THR_W-1:0];
            REG_HOLD:      hold_len = data[CNT_W-1:0];
            REG_RECOVERY:  ramp_len = data[CNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_frame(input logic gv, input logic [15:0] yaw, input bit typed,
                              input frame_result_t typed_res);
        int            gap;
        frame_result_t res;
        gap = draw_wait(send_no_idle);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        gate_ok = gv;
        yaw_rate = yaw;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        res = advance_mode(gv, yaw);
        expected_frames = {expected_frames, (typed ? typed_res : res)};
        frames_sent++;
    endtask

    // Receiver: random stall before each beat, and one long hold-off on request.
    initial
    begin
        int w;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                w = draw_wait(recv_no_idle);
                if (w > 0)
                begin
                    out_stall = 1'b1;
                    repeat (w) @(negedge clk);
                end
            end
            out_stall = 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        frame_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_frames.size() == 0)
            begin
                $display("%0t ns: output beat with nothing expected (mode %0d entered %0d weight %0d)",
                         $time, mode, turn_entered, corr_weight);
                mismatches++;
            end
            else
            begin
                exp_res = expected_frames.pop_front();
                if (mode !== exp_res.mode)
                begin
                    $display("%0t ns: mode expected %0d, actual %0d", $time, exp_res.mode, mode);
                    mismatches++;
                end
                if (turn_entered !== exp_res.entered)
                begin
                    $display("%0t ns: turn_entered expected %0d, actual %0d",
                             $time, exp_res.entered, turn_entered);
                    mismatches++;
                end
                if (corr_weight !== exp_res.scale)
                begin
                    $display("%0t ns: corr_weight expected %0d, actual %0d",
                             $time, exp_res.scale, corr_weight);
                    mismatches++;
                end
            end
        end
    end

    // Ends the run if no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        frame_result_t   row_res;
        logic [THR_W-1:0] thr_a;
        logic [THR_W-1:0] thr_b;
        logic [CNT_W-1:0] len;
        logic [15:0]      yaw;
        logic             gv;
        int               regime;
        int               phase_len;
        int               phase;
        int               m;
        int               top;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        gate_ok = 1'b0;
        yaw_rate = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(CFG_IDX_W'(dir_rows[i].idx), CFG_DATA_W'(dir_rows[i].data));
            else
            begin
                row_res.mode = 2'(dir_rows[i].e_mode);
                row_res.entered = dir_rows[i].e_ent;
                row_res.scale = SCALE_W'(dir_rows[i].e_scale);
                send_frame(dir_rows[i].gv, 16'(dir_rows[i].yaw), dir_rows[i].typed, row_res);
            end
        end

        phase = 0;
        regime = RG_TURN;
        while (frames_sent < FRAME_TARGET)
        begin
            // Thresholds: mostly moderate with hysteresis, sometimes extreme or inverted.
            case ($urandom_range(0, 7))
                0: thr_a = '0;
                1: thr_a = 15'h7FFF;
                default: thr_a = 15'($urandom_range(0, 4000));
            endcase
            if ($urandom_range(0, 5) == 0)
                thr_b = 15'($urandom);
            else
                thr_b = 15'($urandom_range(0, thr_a));
            write_reg(REG_ENTER_THR, {1'($urandom), thr_a});
            write_reg(REG_EXIT_THR, {1'($urandom), thr_b});
            case ($urandom_range(0, 19))
                0, 1: len = '0;
                2:    len = 8'hFF;
                default: len = 8'($urandom_range(1, 6));
            endcase
            write_reg(REG_HOLD, {8'($urandom), len});
            case ($urandom_range(0, 14))
                0, 1: len = '0;
                2:    len = 8'hFF;
                default: len = 8'($urandom_range(1, 12));
            endcase
            write_reg(REG_RECOVERY, {8'($urandom), len});

            send_no_idle = ($urandom_range(0, 3) == 0);
            recv_no_idle = ($urandom_range(0, 3) == 0);
            if (phase == 1)
            begin
                send_no_idle = 1'b1;
                hold_off_req = 1'b1;
            end

            phase_len = $urandom_range(40, 160);
            repeat (phase_len)
            begin
                if ($urandom_range(0, 5) == 0)
                    regime = $urandom_range(RG_TURN, RG_NOISE);
                gv = 1'b1;
                case (regime)
                    RG_TURN:
                    begin
                        top = int'(enter_thr) + 3000;
                        if (top > 32768 || $urandom_range(0, 9) == 0)
                            top = 32768;
                        m = ($urandom_range(0, 7) == 0) ? int'(enter_thr)
                                                        : $urandom_range(enter_thr, top);
                        yaw = yaw_of_mag(m);
                    end
                    RG_CALM:
                    begin
                        m = ($urandom_range(0, 7) == 0) ? int'(exit_thr)
                                                        : $urandom_range(0, exit_thr);
                        yaw = yaw_of_mag(m);
                    end
                    RG_MID:
                        yaw = yaw_of_mag($urandom_range(exit_thr, enter_thr));
                    RG_DROP:
                    begin
                        gv = 1'b0;
                        yaw = 16'($urandom);
                    end
                    default:
                    begin
                        gv = 1'($urandom);
                        yaw = 16'($urandom);
                    end
                endcase
                if ($urandom_range(0, 11) == 0)
                begin
                    gv = 1'($urandom);
                    yaw = 16'($urandom);
                end
                send_frame(gv, yaw, 1'b0, '0);
            end
            phase++;
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
